// File: sv/rfm_pkg.sv
// Shared types and constants of the reciprocal frequency meter.
package rfm_pkg;

  // Fixed field widths
  localparam int FREQ_W     = 24;
  localparam int STATUS_W   = 2;
  localparam int TIMEOUT_W  = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 8;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 1'd1;

  // Register reset values
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET   = 16'd65000;
  localparam logic [CFG_DATA_W-1:0] TICK_RATE_RESET = 24'd1250000;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSIG = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF   = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic step;       // take the request and advance the measurement state
    logic div_start;  // launch the reciprocal division
    logic out_load;   // move the pending result into the output register
  } rfm_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_div;   // the offered tick completes a period
    logic need_emit;  // the offered tick gives a result without division
    logic div_done;   // quotient is ready
    logic out_free;   // output register can take a result this cycle
  } rfm_stat_t;

endpackage

// File: sv/rfm_div.sv
// Restoring divider, one quotient bit per cycle.
module rfm_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             running_r, running_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   shifted;
  logic             fits;

  // Trial subtraction of the divisor from the shifted remainder
  assign shifted = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_comb begin
    running_nxt = running_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    den_nxt     = den_r;
    if (start) begin
      running_nxt = 1'b1;
      cnt_nxt     = CNT_W'(NUM_W - 1);
      rem_nxt     = '0;
      quo_nxt     = num;
      den_nxt     = den;
    end else if (running_r) begin
      rem_nxt = fits ? (shifted - {1'b0, den_r}) : shifted;
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      if (cnt_r == '0) begin
        running_nxt = 1'b0;
        done_nxt    = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      running_r <= running_nxt;
      done_r    <= done_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: sv/rfm_datapath.sv
// Measurement state, configuration registers, divider and output register.
module rfm_datapath #(
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [rfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [rfm_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tready,
  output logic                           out_tvalid,
  output logic [rfm_pkg::FREQ_W-1:0]     out_tdata,
  output logic [rfm_pkg::STATUS_W-1:0]   out_tuser,
  input  rfm_pkg::rfm_cmd_t              cmd,
  output rfm_pkg::rfm_stat_t             stat
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [rfm_pkg::TIMEOUT_W-1:0]  timeout_r;
  logic [rfm_pkg::CFG_DATA_W-1:0] tick_rate_r;

  logic                          phase_r, phase_nxt;      // 1: measuring
  logic                          last_r;
  logic [COUNT_BITS-1:0]         period_r, period_nxt;
  logic [COUNT_BITS-1:0]         period_inc;
  logic [rfm_pkg::TIMEOUT_W-1:0] wait_r, wait_nxt, wait_inc;

  logic                          level, rising;
  logic                          need_div, need_emit;
  logic [rfm_pkg::STATUS_W-1:0]  emit_status;

  logic [rfm_pkg::STATUS_W-1:0]  res_status_r;
  logic                          res_zero_r;

  logic                          out_valid_r;
  logic [rfm_pkg::FREQ_W-1:0]    out_freq_r;
  logic [rfm_pkg::STATUS_W-1:0]  out_status_r;

  logic                          div_done;
  logic [rfm_pkg::FREQ_W-1:0]    quo;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= rfm_pkg::TIMEOUT_RESET;
      tick_rate_r <= rfm_pkg::TICK_RATE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rfm_pkg::REG_TIMEOUT:   timeout_r   <= cfg_wdata[rfm_pkg::TIMEOUT_W-1:0];
        rfm_pkg::REG_TICK_RATE: tick_rate_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Evaluate one tick against the current measurement state
  assign level      = in_tdata[0];
  assign rising     = level & ~last_r;
  assign period_inc = period_r + 1'b1;
  assign wait_inc   = wait_r + 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    period_nxt  = period_r;
    wait_nxt    = wait_r;
    need_div    = 1'b0;
    need_emit   = 1'b0;
    emit_status = rfm_pkg::ST_OK;
    if (!phase_r) begin
      if (rising) begin
        phase_nxt  = 1'b1;
        period_nxt = '0;
        wait_nxt   = '0;
      end else if (wait_inc == '0 || wait_inc >= timeout_r) begin
        wait_nxt    = '0;
        need_emit   = 1'b1;
        emit_status = rfm_pkg::ST_NOSIG;
      end else begin
        wait_nxt = wait_inc;
      end
    end else if (period_r == COUNT_MAX) begin
      phase_nxt   = 1'b0;
      period_nxt  = '0;
      wait_nxt    = '0;
      need_emit   = 1'b1;
      emit_status = rfm_pkg::ST_OVF;
    end else if (rising) begin
      phase_nxt  = 1'b0;
      period_nxt = '0;
      wait_nxt   = '0;
      need_div   = 1'b1;
    end else begin
      period_nxt = period_inc;
    end
  end

  // Advance the measurement state on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      last_r   <= 1'b0;
      period_r <= '0;
      wait_r   <= '0;
    end else if (cmd.step) begin
      phase_r  <= phase_nxt;
      last_r   <= level;
      period_r <= period_nxt;
      wait_r   <= wait_nxt;
    end
  end

  // Hold the kind of the pending result
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      res_status_r <= need_div ? rfm_pkg::ST_OK : emit_status;
      res_zero_r   <= ~need_div;
    end
  end

  // Reciprocal: tick rate over the completed period count
  rfm_div #(
    .NUM_W (rfm_pkg::FREQ_W),
    .DEN_W (COUNT_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (tick_rate_r),
    .den   (period_inc),
    .done  (div_done),
    .quo   (quo)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_freq_r   <= res_zero_r ? '0 : quo;
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_freq_r;
  assign out_tuser  = out_status_r;

  assign stat.need_div  = need_div;
  assign stat.need_emit = need_emit;
  assign stat.div_done  = div_done;
  assign stat.out_free  = ~out_valid_r | out_tready;

  // The wait counter stays clear while a period is being counted
  a_wait_clear_measuring: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> wait_r == '0)
    else $error("wait counter running during a measurement");

  // A result that is not ok carries zero frequency
  a_fail_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != rfm_pkg::ST_OK |-> out_freq_r == '0)
    else $error("non-zero frequency on a failed measurement");

endmodule

// File: sv/rfm_ctrl.sv
// Sequencing state machine: accept tick, run division, hand over result.
module rfm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  rfm_pkg::rfm_stat_t stat,
  output rfm_pkg::rfm_cmd_t  cmd
);

  rfm_pkg::ctrl_state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd.step      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.out_load  = 1'b0;
    in_tready     = 1'b0;
    case (state_r)
      rfm_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.step = 1'b1;
          if (stat.need_div) begin
            cmd.div_start = 1'b1;
            state_nxt     = rfm_pkg::S_DIV;
          end else if (stat.need_emit) begin
            state_nxt = rfm_pkg::S_EMIT;
          end
        end
      end
      rfm_pkg::S_DIV: begin
        if (stat.div_done) begin
          state_nxt = rfm_pkg::S_EMIT;
        end
      end
      rfm_pkg::S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = rfm_pkg::S_IDLE;
        end
      end
      default: state_nxt = rfm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rfm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A completed period always goes through the divider
  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rfm_pkg::S_IDLE && in_tvalid && stat.need_div
    |=> state_r == rfm_pkg::S_DIV)
    else $error("completed period did not start a division");

  // Stay in division until the quotient is ready
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rfm_pkg::S_DIV && !stat.div_done |=> state_r == rfm_pkg::S_DIV)
    else $error("left division before the quotient was ready");

  // Never overwrite a result that has not been taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten");

endmodule

// File: sv/reciprocal_frequency_meter_core.sv
// Reciprocal frequency meter: each request is a reference tick carrying the sampled signal
// level. The meter waits for a rising edge (reporting no-signal at the timeout), counts ticks
// up to the next rising edge and reports tick_rate_hz / count rounded down, or an overflow
// when the period count passes its COUNT_BITS range. A tick that yields no result leaves the
// controller idle; a timeout or overflow result passes the emit state, a completed period the
// division and emit states, with the restoring divider producing one of the 24 quotient bits
// per cycle. A result waits in the output register without blocking the next tick, but no new
// tick is taken while a division or an earlier result hand-over is pending.
module reciprocal_frequency_meter_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [rfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // ticks
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rfm_pkg::IN_DATA_W-1:0]  in_tdata,   // [0] signal_level, [7:1] zero
  // results
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rfm_pkg::FREQ_W-1:0]     out_tdata,  // [23:0] frequency_hz
  output logic [rfm_pkg::STATUS_W-1:0]   out_tuser   // [1:0] status
);

  rfm_pkg::rfm_cmd_t  cmd;
  rfm_pkg::rfm_stat_t stat;

  rfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rfm_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
